>>> design/ple_pkg.sv
package ple_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 2;
    localparam int TOT_W  = 5;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_BACK  = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_TRAVERSE  = 3'd6,
        REQ_COUNT     = 3'd7
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic more;
    } t_stat;

endpackage

>>> design/ple_datapath.sv
module ple_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ple_pkg::t_cmd               i_cmd,
    output ple_pkg::t_stat              o_stat,
    input  logic [ple_pkg::REQ_W-1:0]   i_req,
    input  logic [ple_pkg::POS_W-1:0]   i_pos,
    input  logic [ple_pkg::VAL_W-1:0]   i_val,
    output logic [ple_pkg::ST_W-1:0]    o_status,
    output logic [ple_pkg::VAL_W-1:0]   o_value,
    output logic [ple_pkg::TOT_W-1:0]   o_total,
    output logic                        o_last
);

    logic [ple_pkg::VAL_W-1:0]  r_store [ple_pkg::DEPTH];
    logic [ple_pkg::CNT_W-1:0]  r_cnt;
    ple_pkg::t_req              r_req;
    logic [ple_pkg::POS_W-1:0]  r_pos;
    logic [ple_pkg::VAL_W-1:0]  r_val;
    ple_pkg::t_status           r_status;
    logic [ple_pkg::VAL_W-1:0]  r_value;
    logic                       r_last;
    logic                       r_trav;
    logic [ple_pkg::IDX_W-1:0]  r_tidx;

    ple_pkg::t_status           n_status;
    logic                       op_ins;
    logic                       op_del;
    logic                       op_trav;
    logic [ple_pkg::CMP_W-1:0]  k;
    logic [ple_pkg::CMP_W-1:0]  n;
    logic [ple_pkg::CMP_W-1:0]  p;
    logic                       full;
    logic [ple_pkg::IDX_W-1:0]  rd_idx;
    logic [ple_pkg::VAL_W-1:0]  rd_data;
    logic [ple_pkg::IDX_W-1:0]  tidx_nxt;

    always_comb begin
        n        = ple_pkg::CMP_W'(r_cnt);
        p        = ple_pkg::CMP_W'(r_pos);
        full     = (n == ple_pkg::CMP_W'(ple_pkg::DEPTH));
        n_status = ple_pkg::ST_OK;
        op_ins   = 1'b0;
        op_del   = 1'b0;
        op_trav  = 1'b0;
        k        = '0;
        case (r_req)
            ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK: begin
                if (full) begin
                    n_status = ple_pkg::ST_FULL;
                end else begin
                    op_ins = 1'b1;
                    k      = (r_req == ple_pkg::REQ_INS_FRONT) ? '0 : n;
                end
            end
            ple_pkg::REQ_INS_POS: begin
                // an empty list refuses positional insert
                if (n == '0 || p == '0 || p > n + 1'b1) begin
                    n_status = ple_pkg::ST_BAD_POS;
                end else if (full) begin
                    n_status = ple_pkg::ST_FULL;
                end else begin
                    op_ins = 1'b1;
                    k      = p - 1'b1;
                end
            end
            ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_BACK, ple_pkg::REQ_DEL_POS: begin
                if (n == '0) begin
                    n_status = ple_pkg::ST_EMPTY;
                end else if (r_req == ple_pkg::REQ_DEL_POS && (p == '0 || p > n)) begin
                    n_status = ple_pkg::ST_BAD_POS;
                end else begin
                    op_del = 1'b1;
                    case (r_req)
                        ple_pkg::REQ_DEL_FRONT: k = '0;
                        ple_pkg::REQ_DEL_BACK:  k = n - 1'b1;
                        default:                k = p - 1'b1;
                    endcase
                end
            end
            ple_pkg::REQ_TRAVERSE: begin
                if (n == '0) begin
                    n_status = ple_pkg::ST_EMPTY;
                end else begin
                    op_trav = 1'b1;
                end
            end
            default: begin
                n_status = ple_pkg::ST_OK;
            end
        endcase
    end

    assign tidx_nxt = r_tidx + 1'b1;
    assign rd_idx   = i_cmd.exec ? k[ple_pkg::IDX_W-1:0] : tidx_nxt;
    assign rd_data  = r_store[rd_idx];

    // insert writes the target entry and shifts the entries after it up; delete shifts the entries from it on down
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < ple_pkg::DEPTH; i++) begin
                if (op_ins) begin
                    if (ple_pkg::CMP_W'(i) == k) begin
                        r_store[i] <= r_val;
                    end else if (ple_pkg::CMP_W'(i) > k && ple_pkg::CMP_W'(i) <= n && i > 0) begin
                        r_store[i] <= r_store[(i > 0) ? i - 1 : 0];
                    end
                end else if (op_del) begin
                    if (ple_pkg::CMP_W'(i) >= k && ple_pkg::CMP_W'(i) + 1'b1 < n
                        && i < ple_pkg::DEPTH - 1) begin
                        r_store[i] <= r_store[(i < ple_pkg::DEPTH - 1) ? i + 1 : i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_trav <= 1'b0;
            r_last <= 1'b0;
            r_tidx <= '0;
        end else begin
            if (i_cmd.exec) begin
                if (op_ins) begin
                    r_cnt <= r_cnt + 1'b1;
                end else if (op_del) begin
                    r_cnt <= r_cnt - 1'b1;
                end
                r_trav <= op_trav;
                r_last <= op_trav ? (n == ple_pkg::CMP_W'(1)) : 1'b1;
                r_tidx <= '0;
            end else if (i_cmd.step) begin
                r_tidx <= tidx_nxt;
                r_last <= (ple_pkg::CMP_W'(r_tidx) + ple_pkg::CMP_W'(2) == n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= ple_pkg::t_req'(i_req);
            r_pos <= i_pos;
            r_val <= i_val;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_value  <= (op_del || op_trav) ? rd_data : '0;
        end else if (i_cmd.step) begin
            r_value  <= rd_data;
        end
    end

    assign o_stat.more = r_trav && !r_last;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_total     = ple_pkg::TOT_W'(r_cnt);
    assign o_last      = r_last;

endmodule

>>> design/ple_ctrl.sv
module ple_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ple_pkg::t_cmd   o_cmd,
    input  ple_pkg::t_stat  i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   in_beat;
    logic   out_beat;

    assign in_beat  = i_in_valid && r_in_ready;
    assign out_beat = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    // traverse keeps emitting until the tail beat is taken
                    if (out_beat && !i_stat.more) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd.load  = in_beat;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.step  = out_beat && i_stat.more;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

>>> design/positional_list_engine_core.sv
// a request's first result beat is registered in the exec state, which follows the
// state that takes its input beat; no new request is taken until the last result
// beat of the previous one is taken; a traverse sends one beat per cycle while the
// receiver is ready, one for each stored element
// the element register file shifts in the exec step
// reset (i_rst_n low, synchronous) empties the list; stored values are not cleared
module positional_list_engine_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // position [4:0], new_value [36:5], zero pad [39:37]
    input  logic [ple_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // req_type [2:0]
    input  logic [ple_pkg::REQ_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // item_value [31:0], element_total [36:32], zero pad [39:37]
    output logic [ple_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // status [1:0]
    output logic [ple_pkg::ST_W-1:0]          o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);

    localparam int PAD_W = ple_pkg::OUT_DATA_W - ple_pkg::VAL_W - ple_pkg::TOT_W;

    ple_pkg::t_cmd              cmd;
    ple_pkg::t_stat             stat;
    logic [ple_pkg::VAL_W-1:0]  value;
    logic [ple_pkg::TOT_W-1:0]  total;

    ple_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    ple_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_req    (i_s_axis_tuser),
        .i_pos    (i_s_axis_tdata[ple_pkg::POS_W-1:0]),
        .i_val    (i_s_axis_tdata[ple_pkg::POS_W +: ple_pkg::VAL_W]),
        .o_status (o_m_axis_tuser),
        .o_value  (value),
        .o_total  (total),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, total, value};

endmodule

>>> verif/list_reply_checker.sv
`timescale 1ns / 100ps

module list_reply_checker
    import ple_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // position [4:0], new_value [36:5], zero pad [39:37]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // req_type [2:0]
    input  logic [REQ_W-1:0]      i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // item_value [31:0], element_total [36:32], zero pad [39:37]
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // status [1:0]
    input  logic [ST_W-1:0]       i_m_tuser,
    input  logic                  i_m_tlast,
    output int                    o_mismatches,
    output int                    o_replies_due,
    output int                    o_list_size
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] value;
        logic [TOT_W-1:0] total;
        logic             last;
    } t_reply;

    logic [VAL_W-1:0] shadow_list [DEPTH];
    int               shadow_count   = 0;
    int               mismatch_count = 0;
    int               replies_due    = 0;
    int               list_size      = 0;
    t_reply           list_replies [$];

    assign o_mismatches  = mismatch_count;
    assign o_replies_due = replies_due;
    assign o_list_size   = list_size;

    function automatic void push_reply(t_status st, logic [VAL_W-1:0] v, logic last);
        t_reply r;
        r.status = st;
        r.value  = v;
        r.total  = TOT_W'(shadow_count);
        r.last   = last;
        list_replies.push_back(r);
    endfunction

    function automatic void shadow_insert(int idx, logic [VAL_W-1:0] v);
        for (int i = shadow_count; i > idx; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[idx] = v;
        shadow_count++;
    endfunction

    function automatic logic [VAL_W-1:0] shadow_remove(int idx);
        logic [VAL_W-1:0] v;
        v = shadow_list[idx];
        for (int i = idx; i + 1 < shadow_count; i++)
            shadow_list[i] = shadow_list[i+1];
        shadow_count--;
        return v;
    endfunction

    function automatic void apply_list_request(t_req req, int pos, logic [VAL_W-1:0] val);
        int n;
        n = shadow_count;
        case (req)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (n >= DEPTH) begin
                    push_reply(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_insert((req == REQ_INS_FRONT) ? 0 : n, val);
                    push_reply(ST_OK, '0, 1'b1);
                end
            end
            REQ_INS_POS: begin
                // insert into an empty list is refused as a bad position
                if (n == 0 || pos < 1 || pos > n + 1) begin
                    push_reply(ST_BAD_POS, '0, 1'b1);
                end else if (n >= DEPTH) begin
                    push_reply(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_insert(pos - 1, val);
                    push_reply(ST_OK, '0, 1'b1);
                end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: begin
                if (n == 0) begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    val = shadow_remove((req == REQ_DEL_FRONT) ? 0 : n - 1);
                    push_reply(ST_OK, val, 1'b1);
                end
            end
            REQ_DEL_POS: begin
                if (n == 0) begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end else if (pos < 1 || pos > n) begin
                    push_reply(ST_BAD_POS, '0, 1'b1);
                end else begin
                    val = shadow_remove(pos - 1);
                    push_reply(ST_OK, val, 1'b1);
                end
            end
            REQ_TRAVERSE: begin
                if (n == 0) begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        push_reply(ST_OK, shadow_list[i], i == n - 1);
                end
            end
            default: begin
                push_reply(ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            shadow_count = 0;
            list_replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tuser);
                got.value  = i_m_tdata[VAL_W-1:0];
                got.total  = i_m_tdata[VAL_W +: TOT_W];
                got.last   = i_m_tlast;
                if (list_replies.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected result beat: status %0d value %h total %0d last %0b",
                                 got.status, got.value, got.total, got.last);
                    mismatch_count++;
                end else begin
                    want = list_replies.pop_front();
                    if (got.status !== want.status || got.value !== want.value ||
                        got.total !== want.total || got.last !== want.last) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected: status %0d value %h total %0d last %0b",
                                     want.status, want.value, want.total, want.last);
                            $display("  actual  : status %0d value %h total %0d last %0b",
                                     got.status, got.value, got.total, got.last);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_list_request(t_req'(i_s_tuser), int'(i_s_tdata[POS_W-1:0]),
                                   i_s_tdata[POS_W +: VAL_W]);
        end
        replies_due <= list_replies.size();
        list_size   <= shadow_count;
    end

endmodule

>>> verif/positional_list_engine_core_test.sv
`timescale 1ns / 100ps

module positional_list_engine_core_test;
    import ple_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 24;

    typedef enum int {SWEEP_GROW, SWEEP_SHRINK, SWEEP_MIX} t_sweep;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [REQ_W-1:0]      i_s_axis_tuser = REQ_COUNT;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [ST_W-1:0]       o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    int mismatches;
    int replies_due;
    int list_size;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    positional_list_engine_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    list_reply_checker u_reply_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .i_m_tuser     (o_m_axis_tuser),
        .i_m_tlast     (o_m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_replies_due (replies_due),
        .o_list_size   (list_size)
    );

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ends the run if no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL positional_list_engine_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(t_req req, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        i_s_axis_tdata  <= {3'b000, val, pos};
        i_s_axis_tuser  <= req;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold the input off until every predicted beat has come back
    task automatic wait_for_replies();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (replies_due != 0);
    endtask

    function automatic t_req pick_req(t_sweep mode);
        int r;
        r = $urandom_range(99);
        if (mode == SWEEP_MIX)
            return t_req'(REQ_W'($urandom_range(7)));
        if (r < 70)
            return t_req'(REQ_W'((mode == SWEEP_GROW) ? $urandom_range(2) : $urandom_range(5, 3)));
        if (r < 85)
            return t_req'(REQ_W'((mode == SWEEP_GROW) ? $urandom_range(5, 3) : $urandom_range(2)));
        return t_req'(REQ_W'($urandom_range(7, 6)));
    endfunction

    function automatic logic [POS_W-1:0] pick_position(t_req req, int n);
        int r;
        int hi;
        r = $urandom_range(99);
        if (req != REQ_INS_POS && req != REQ_DEL_POS)
            return POS_W'($urandom_range(31));
        hi = (req == REQ_INS_POS) ? n + 1 : n;
        if (hi < 1)
            hi = 1;
        if (r < 80)
            return POS_W'($urandom_range(hi, 1));
        if (r < 90)
            return (r % 2 == 0) ? '0 : POS_W'(hi + 1);
        return POS_W'($urandom_range(31));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(49))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // grow runs past full, shrink runs past empty, mix is a short uniform burst
    task automatic run_sweep(t_sweep mode);
        int tail;
        int sent;
        t_req req;
        tail = 0;
        sent = 0;
        while (((mode == SWEEP_MIX) ? (sent < 8) : (tail < 4)) && sent < 200) begin
            if ((mode == SWEEP_GROW && list_size == DEPTH) ||
                (mode == SWEEP_SHRINK && list_size == 0))
                tail++;
            req = pick_req(mode);
            send_request(req, pick_position(req, list_size), pick_value());
            sent++;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corners
        send_request(REQ_COUNT,     5'd0,  32'h0000_0000);
        send_request(REQ_TRAVERSE,  5'd0,  32'h0000_0000);
        send_request(REQ_DEL_FRONT, 5'd0,  32'h0000_0000);
        send_request(REQ_DEL_BACK,  5'd0,  32'h0000_0000);
        send_request(REQ_DEL_POS,   5'd1,  32'h0000_0000);
        send_request(REQ_INS_POS,   5'd1,  32'h1111_1111);
        // value extremes at both ends
        send_request(REQ_INS_FRONT, 5'd31, 32'h7FFF_FFFF);
        send_request(REQ_INS_BACK,  5'd0,  32'h8000_0000);
        send_request(REQ_INS_FRONT, 5'd0,  32'h0000_0000);
        send_request(REQ_INS_BACK,  5'd31, 32'hFFFF_FFFF);
        // positional insert: zero, past count + 1, at count + 1, at head, far out
        send_request(REQ_INS_POS,   5'd0,  32'h2222_2222);
        send_request(REQ_INS_POS,   5'd6,  32'h3333_3333);
        send_request(REQ_INS_POS,   5'd5,  32'h1234_5678);
        send_request(REQ_INS_POS,   5'd1,  32'hA5A5_A5A5);
        send_request(REQ_INS_POS,   5'd31, 32'h4444_4444);
        send_request(REQ_TRAVERSE,  5'd0,  32'h0000_0000);
        // positional delete: zero, count + 1, far out, middle, tail
        send_request(REQ_DEL_POS,   5'd0,  32'h0000_0000);
        send_request(REQ_DEL_POS,   5'd7,  32'h0000_0000);
        send_request(REQ_DEL_POS,   5'd31, 32'h0000_0000);
        send_request(REQ_DEL_POS,   5'd3,  32'h0000_0000);
        send_request(REQ_DEL_POS,   5'd5,  32'h0000_0000);
        send_request(REQ_DEL_FRONT, 5'd0,  32'h0000_0000);
        send_request(REQ_DEL_BACK,  5'd0,  32'h0000_0000);
        send_request(REQ_COUNT,     5'd0,  32'h0000_0000);
        send_request(REQ_TRAVERSE,  5'd0,  32'h0000_0000);
        wait_for_replies();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase
            run_sweep(SWEEP_GROW);
            run_sweep(SWEEP_SHRINK);
            run_sweep(SWEEP_MIX);
            wait_for_replies();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && replies_due == 0) begin
            $display("PASS positional_list_engine_core");
        end else begin
            $display("FAIL positional_list_engine_core");
        end
        $finish;
    end

endmodule
